// ----- rtl/iso_week_from_date_macros.svh -----
// Assertion helpers, clocked on clk, off while arst_n is low.
`ifndef ISO_WEEK_FROM_DATE_MACROS_SVH
`define ISO_WEEK_FROM_DATE_MACROS_SVH

// same-cycle implication
`define IWFD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define IWFD_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ----- rtl/iwfd_pkg.sv -----
package iwfd_pkg;

	// request to result, in cycles
	localparam int LATENCY = 5;

	localparam logic [13:0] YR_12800 = 14'd12800;
	localparam logic [13:0] YR_6400  = 14'd6400;
	localparam logic [13:0] YR_3200  = 14'd3200;
	localparam logic [13:0] YR_1600  = 14'd1600;
	localparam logic [13:0] YR_800   = 14'd800;
	localparam logic [13:0] YR_400   = 14'd400;

	localparam logic [5:0] WEEKS_LONG  = 6'd53;
	localparam logic [5:0] WEEKS_SHORT = 6'd52;

	// floor(n / 7) for n < 512 as (n * 2341) >> 14
	localparam logic [11:0] DIV7_MUL = 12'd2341;

	// Sunday-based weekday codes
	localparam logic [2:0] WD_SUN = 3'd0;
	localparam logic [2:0] WD_WED = 3'd3;
	localparam logic [2:0] WD_THU = 3'd4;
	localparam logic [2:0] WD_MON7 = 3'd7;

	localparam logic [3:0] MON_JAN = 4'd1;
	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_MAR = 4'd3;
	localparam logic [3:0] MON_DEC = 4'd12;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} req_t;

	typedef struct packed {
		logic [13:0] iso_year;
		logic [5:0]  iso_week;
		logic        valid_res;
	} res_t;

	// after the year has been reduced modulo 400
	typedef struct packed {
		logic        ok;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [8:0]  yr400;
	} yred_t;

	// ready for the week divide and rollover
	typedef struct packed {
		logic        ok;
		logic [13:0] year;
		logic [8:0]  numer;
		logic [5:0]  wk_cur;
		logic [5:0]  wk_prev;
	} cal_t;

	function automatic logic [13:0] red_step(input logic [13:0] x, input logic [13:0] k);
		return (x >= k) ? x - k : x;
	endfunction

	// x is a year modulo 400
	function automatic logic leap400(input logic [8:0] x);
		return (x[1:0] == 2'b00) && (x != 9'd100) && (x != 9'd200) && (x != 9'd300);
	endfunction

	// x + x/4 - x/100 for x < 400
	function automatic logic [9:0] year_key(input logic [8:0] x);
		logic [1:0] c;
		c = (x >= 9'd300) ? 2'd3 : (x >= 9'd200) ? 2'd2 : (x >= 9'd100) ? 2'd1 : 2'd0;
		return {1'b0, x} + {3'b000, x[8:2]} - {8'h00, c};
	endfunction

	// modulo 7 by folding octal digits, since 8 = 1 mod 7
	function automatic logic [2:0] mod7(input logic [9:0] x);
		logic [4:0] s1;
		logic [3:0] s2;
		s1 = {4'h0, x[9]} + {2'b00, x[8:6]} + {2'b00, x[5:3]} + {2'b00, x[2:0]};
		s2 = {2'b00, s1[4:3]} + {1'b0, s1[2:0]};
		return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] m);
		case (m)
			4'd1:    return 9'd0;
			4'd2:    return 9'd31;
			4'd3:    return 9'd59;
			4'd4:    return 9'd90;
			4'd5:    return 9'd120;
			4'd6:    return 9'd151;
			4'd7:    return 9'd181;
			4'd8:    return 9'd212;
			4'd9:    return 9'd243;
			4'd10:   return 9'd273;
			4'd11:   return 9'd304;
			4'd12:   return 9'd334;
			default: return 9'd0;
		endcase
	endfunction

	function automatic logic [2:0] month_key(input logic [3:0] m);
		case (m)
			4'd1:    return 3'd0;
			4'd2:    return 3'd3;
			4'd3:    return 3'd2;
			4'd4:    return 3'd5;
			4'd5:    return 3'd0;
			4'd6:    return 3'd3;
			4'd7:    return 3'd5;
			4'd8:    return 3'd1;
			4'd9:    return 3'd4;
			4'd10:   return 3'd6;
			4'd11:   return 3'd2;
			4'd12:   return 3'd4;
			default: return 3'd0;
		endcase
	endfunction

endpackage

// ----- rtl/iwfd_yred.sv -----
// Stages 1 and 2: range check and year modulo 400 by restoring subtraction.
module iwfd_yred (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  iwfd_pkg::req_t  req,
	output logic            out_vld,
	output iwfd_pkg::yred_t out
);

	logic        vld_s1;
	logic        ok_s1;
	logic [13:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [11:0] part_s1;

	logic        vld_s2;
	iwfd_pkg::yred_t data_s2;

	logic        ok_c;
	logic [13:0] t1, t2, t3;
	logic [13:0] u0, u1, u2, u3;

	always_comb begin
		ok_c = (req.month >= iwfd_pkg::MON_JAN) && (req.month <= iwfd_pkg::MON_DEC) &&
			(req.day != 5'd0);
		t1 = iwfd_pkg::red_step(req.year, iwfd_pkg::YR_12800);
		t2 = iwfd_pkg::red_step(t1, iwfd_pkg::YR_6400);
		t3 = iwfd_pkg::red_step(t2, iwfd_pkg::YR_3200);
	end

	always_comb begin
		u0 = {2'b00, part_s1};
		u1 = iwfd_pkg::red_step(u0, iwfd_pkg::YR_1600);
		u2 = iwfd_pkg::red_step(u1, iwfd_pkg::YR_800);
		u3 = iwfd_pkg::red_step(u2, iwfd_pkg::YR_400);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1    <= ok_c;
		year_s1  <= req.year;
		month_s1 <= req.month;
		day_s1   <= req.day;
		part_s1  <= t3[11:0];

		data_s2.ok    <= ok_s1;
		data_s2.year  <= year_s1;
		data_s2.month <= month_s1;
		data_s2.day   <= day_s1;
		data_s2.yr400 <= u3[8:0];
	end

	assign out_vld = vld_s2;
	assign out     = data_s2;

endmodule

// ----- rtl/iwfd_cal.sv -----
// Stages 3 and 4: day of year, weekdays, week counts of this and last year.
module iwfd_cal (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  iwfd_pkg::yred_t in,
	output logic            out_vld,
	output iwfd_pkg::cal_t  out
);

	logic        vld_s3;
	logic        ok_s3;
	logic [13:0] year_s3;
	logic [8:0]  doy_s3;
	logic [9:0]  sum_date_s3;
	logic [9:0]  sum_ja_s3;
	logic [9:0]  sum_jp_s3;
	logic        leap_a_s3;
	logic        leap_p_s3;

	logic           vld_s4;
	iwfd_pkg::cal_t data_s4;

	logic [8:0] a, p, q, yy;
	logic       la, lp;
	logic [9:0] sum_date, sum_ja, sum_jp;
	logic [8:0] doy;

	// a: this year, p: the year before, q: two years before, all modulo 400
	always_comb begin
		a  = in.yr400;
		p  = (a == 9'd0) ? 9'd399 : a - 9'd1;
		q  = (a == 9'd0) ? 9'd398 : (a == 9'd1) ? 9'd399 : a - 9'd2;
		la = iwfd_pkg::leap400(a);
		lp = iwfd_pkg::leap400(p);
		yy = (in.month < iwfd_pkg::MON_MAR) ? p : a;
		sum_date = iwfd_pkg::year_key(yy) + {7'h00, iwfd_pkg::month_key(in.month)} +
			{5'h00, in.day};
		// 1 January: month key 0, day 1, counted from the previous year
		sum_ja = iwfd_pkg::year_key(p) + 10'd1;
		sum_jp = iwfd_pkg::year_key(q) + 10'd1;
		doy = iwfd_pkg::month_start(in.month) + {4'h0, in.day} +
			{8'h00, (in.month > iwfd_pkg::MON_FEB) && la};
	end

	logic [2:0] sd, ja, jp, dow;
	logic [8:0] numer;
	logic [5:0] wk_cur, wk_prev;

	always_comb begin
		sd  = iwfd_pkg::mod7(sum_date_s3);
		dow = (sd == iwfd_pkg::WD_SUN) ? iwfd_pkg::WD_MON7 : sd;
		numer = doy_s3 + 9'd10 - {6'h00, dow};
		ja = iwfd_pkg::mod7(sum_ja_s3);
		jp = iwfd_pkg::mod7(sum_jp_s3);
		wk_cur = ((ja == iwfd_pkg::WD_THU) || (leap_a_s3 && (ja == iwfd_pkg::WD_WED))) ?
			iwfd_pkg::WEEKS_LONG : iwfd_pkg::WEEKS_SHORT;
		wk_prev = ((jp == iwfd_pkg::WD_THU) || (leap_p_s3 && (jp == iwfd_pkg::WD_WED))) ?
			iwfd_pkg::WEEKS_LONG : iwfd_pkg::WEEKS_SHORT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s3 <= in_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		ok_s3       <= in.ok;
		year_s3     <= in.year;
		doy_s3      <= doy;
		sum_date_s3 <= sum_date;
		sum_ja_s3   <= sum_ja;
		sum_jp_s3   <= sum_jp;
		leap_a_s3   <= la;
		leap_p_s3   <= lp;

		data_s4.ok      <= ok_s3;
		data_s4.year    <= year_s3;
		data_s4.numer   <= numer;
		data_s4.wk_cur  <= wk_cur;
		data_s4.wk_prev <= wk_prev;
	end

	assign out_vld = vld_s4;
	assign out     = data_s4;

endmodule

// ----- rtl/iwfd_roll.sv -----
// Stage 5: divide by 7, roll the week into the neighbouring year, result register.
module iwfd_roll (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  iwfd_pkg::cal_t in,
	output logic           done,
	output iwfd_pkg::res_t result
);

	logic           done_s5;
	iwfd_pkg::res_t result_s5;

	logic [20:0]    prod;
	logic [5:0]     week;
	iwfd_pkg::res_t res_c;

	always_comb begin
		prod = {12'h000, in.numer} * {9'h000, iwfd_pkg::DIV7_MUL};
		week = prod[19:14];
		res_c.valid_res = in.ok;
		if (!in.ok) begin
			res_c.iso_year = 14'd0;
			res_c.iso_week = 6'd0;
		end else if (week == 6'd0) begin
			res_c.iso_year = in.year - 14'd1;
			res_c.iso_week = in.wk_prev;
		end else if (week > in.wk_cur) begin
			res_c.iso_year = in.year + 14'd1;
			res_c.iso_week = 6'd1;
		end else begin
			res_c.iso_year = in.year;
			res_c.iso_week = week;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5 <= 1'b0;
		end else begin
			done_s5 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_s5 <= res_c;
	end

	assign done   = done_s5;
	assign result = result_s5;

endmodule

// ----- rtl/iso_week_from_date.sv -----
// channel   | ports              | handshake
// ----------+--------------------+-------------------------------------------
// request   | start, request     | taken at a rising edge with start and !busy
// result    | done, result       | done high for one cycle, no back-pressure
//
// One request a cycle; results leave in the order of their requests.
// The five stages are: range check with year mod 400 (two stages of three
// subtract steps), day of year and weekday sums, mod-7 folding, then the
// divide by 7 and year rollover. busy never rises.
// Reset clears the stage valid bits only; requests in flight are dropped.
module iso_week_from_date (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  iwfd_pkg::req_t request,
	output logic           done,
	output iwfd_pkg::res_t result
);

	logic            yred_vld;
	iwfd_pkg::yred_t yred_data;
	logic            cal_vld;
	iwfd_pkg::cal_t  cal_data;

	// every stage moves on each cycle
	assign busy = 1'b0;

	iwfd_yred u_yred (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.req     (request),
		.out_vld (yred_vld),
		.out     (yred_data)
	);

	iwfd_cal u_cal (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (yred_vld),
		.in      (yred_data),
		.out_vld (cal_vld),
		.out     (cal_data)
	);

	iwfd_roll u_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (cal_vld),
		.in     (cal_data),
		.done   (done),
		.result (result)
	);

endmodule

// ----- rtl/iwfd_chk.sv -----
`include "iso_week_from_date_macros.svh"

module iwfd_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input iwfd_pkg::res_t result
);

	localparam int Lat = iwfd_pkg::LATENCY;

	logic taken;
	logic cleared;
	logic week_ok;

	assign taken   = start && !busy;
	assign cleared = (result.iso_week == 6'd0) && (result.iso_year == 14'd0);
	assign week_ok = (result.iso_week >= 6'd1) && (result.iso_week <= 6'd53);

	`IWFD_ASSERT_IMP(a_never_busy, start, !busy, "busy raised")
	`IWFD_ASSERT_DLY(a_latency, taken, Lat, done, "result missing after request")
	`IWFD_ASSERT_IMP(a_no_spurious, done, $past(taken, Lat), "result without request")
	`IWFD_ASSERT_IMP(a_invalid_zero, done && !result.valid_res, cleared, "invalid not cleared")
	`IWFD_ASSERT_IMP(a_week_range, done && result.valid_res, week_ok, "week out of range")

endmodule

bind iso_week_from_date iwfd_chk u_iwfd_chk (.*);
